// ===== hdl/dra_pkg.sv =====
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and constants for the DNS reply address parser.
// ----------------------------------------------------------------------------
package dra_pkg;

    localparam logic [31:0] SERVER_ADDR_RESET = 32'h0A00_0202;
    localparam logic [15:0] EXPECTED_ID_RESET = 16'h0000;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID    = 8'd1;

    localparam logic [3:0] HEADER_BYTES  = 4'd12;
    localparam logic [3:0] FIXED_BYTES   = 4'd10;
    localparam logic [3:0] ADDR_BYTES    = 4'd4;
    localparam logic [3:0] QTAIL_BYTES   = 4'd4;
    localparam logic [7:0] RESPONSE_MASK = 8'h80;
    localparam logic [15:0] TYPE_A       = 16'd1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QLABEL = 4'd2,
        PH_QPTR   = 4'd3,
        PH_QTAIL  = 4'd4,
        PH_ANAME  = 4'd5,
        PH_ALABEL = 4'd6,
        PH_APTR   = 4'd7,
        PH_AFIXED = 4'd8,
        PH_RDATA  = 4'd9,
        PH_ADDR   = 4'd10,
        PH_DONE   = 4'd11
    } phase_t;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
    } result_t;

endpackage

// ===== hdl/dra_parse.sv =====
// ----------------------------------------------------------------------------
// dra_parse
// Per-packet parse state and the next-state logic, one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module dra_parse
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] source_address,
    input  logic [31:0] server_address,
    input  logic [15:0] expected_id,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [15:0] answers_left_reg, answers_left_next;
    logic [3:0]  field_count_reg, field_count_next;
    logic [15:0] record_type_reg, record_type_next;
    logic [15:0] record_length_reg, record_length_next;
    logic [31:0] addr_capture_reg, addr_capture_next;
    logic        rejected_reg, rejected_next;
    logic        found_reg, found_next;

    always_comb
    begin
        logic [3:0]  hc_inc;
        logic [3:0]  fc_inc;
        logic [15:0] skip_dec;
        logic [15:0] ans_dec;
        logic        is_ptr;

        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        skip_count_next    = skip_count_reg;
        answers_left_next  = answers_left_reg;
        field_count_next   = field_count_reg;
        record_type_next   = record_type_reg;
        record_length_next = record_length_reg;
        addr_capture_next  = addr_capture_reg;
        rejected_next      = rejected_reg;
        found_next         = found_reg;

        hc_inc   = header_count_reg + 4'd1;
        fc_inc   = field_count_reg + 4'd1;
        skip_dec = skip_count_reg - 16'd1;
        ans_dec  = answers_left_reg - 16'd1;
        is_ptr   = (data_byte[7:6] == 2'b11);

        if (!rejected_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    case (header_count_reg)
                        4'd0:
                        begin
                            if (source_address != server_address)
                                rejected_next = 1'b1;
                            record_type_next = {8'h00, data_byte};
                        end
                        4'd1:
                        begin
                            if ({record_type_reg[7:0], data_byte} != expected_id)
                                rejected_next = 1'b1;
                        end
                        4'd2:
                        begin
                            if ((data_byte & RESPONSE_MASK) == 8'h00)
                                rejected_next = 1'b1;
                        end
                        4'd6:    answers_left_next = {data_byte, 8'h00};
                        4'd7:    answers_left_next = answers_left_reg | {8'h00, data_byte};
                        default: ;
                    endcase
                    header_count_next = hc_inc;
                    if (hc_inc >= HEADER_BYTES)
                    begin
                        if (answers_left_next == 16'd0)
                            rejected_next = 1'b1;
                        phase_next = PH_QNAME;
                    end
                end
                PH_QNAME, PH_ANAME:
                begin
                    if (data_byte == 8'h00)
                    begin
                        if (phase_reg == PH_ANAME)
                        begin
                            field_count_next = 4'd0;
                            phase_next       = PH_AFIXED;
                        end
                        else
                        begin
                            skip_count_next = {12'h000, QTAIL_BYTES};
                            phase_next      = PH_QTAIL;
                        end
                    end
                    else if (is_ptr)
                        phase_next = (phase_reg == PH_ANAME) ? PH_APTR : PH_QPTR;
                    else
                    begin
                        skip_count_next = {8'h00, data_byte};
                        phase_next = (phase_reg == PH_ANAME) ? PH_ALABEL : PH_QLABEL;
                    end
                end
                PH_QLABEL:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_QNAME;
                end
                PH_QPTR:
                begin
                    skip_count_next = {12'h000, QTAIL_BYTES};
                    phase_next      = PH_QTAIL;
                end
                PH_QTAIL:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_ANAME;
                end
                PH_ALABEL:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_ANAME;
                end
                PH_APTR:
                begin
                    field_count_next = 4'd0;
                    phase_next       = PH_AFIXED;
                end
                PH_AFIXED:
                begin
                    case (field_count_reg)
                        4'd0:    record_type_next = {data_byte, 8'h00};
                        4'd1:    record_type_next = record_type_reg | {8'h00, data_byte};
                        4'd8:    record_length_next = {data_byte, 8'h00};
                        4'd9:    record_length_next = record_length_reg | {8'h00, data_byte};
                        default: ;
                    endcase
                    field_count_next = fc_inc;
                    if (fc_inc >= FIXED_BYTES)
                    begin
                        field_count_next = 4'd0;
                        if (record_type_next == TYPE_A && record_length_next == 16'd4)
                        begin
                            addr_capture_next = 32'h0;
                            phase_next        = PH_ADDR;
                        end
                        else if (record_length_next == 16'd0)
                        begin
                            answers_left_next = ans_dec;
                            phase_next = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                        end
                        else
                        begin
                            skip_count_next = record_length_next;
                            phase_next      = PH_RDATA;
                        end
                    end
                end
                PH_RDATA:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        answers_left_next = ans_dec;
                        phase_next = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
                PH_ADDR:
                begin
                    addr_capture_next = {addr_capture_reg[23:0], data_byte};
                    field_count_next  = fc_inc;
                    if (fc_inc >= ADDR_BYTES)
                    begin
                        found_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // result of the packet, valid when the last byte is stepped
    assign res.found   = found_next;
    assign res.address = found_next ? addr_capture_next : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 4'd0;
            skip_count_reg    <= 16'd0;
            answers_left_reg  <= 16'd0;
            field_count_reg   <= 4'd0;
            record_type_reg   <= 16'd0;
            record_length_reg <= 16'd0;
            addr_capture_reg  <= 32'h0;
            rejected_reg      <= 1'b0;
            found_reg         <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg         <= PH_HEADER;
                header_count_reg  <= 4'd0;
                skip_count_reg    <= 16'd0;
                answers_left_reg  <= 16'd0;
                field_count_reg   <= 4'd0;
                record_type_reg   <= 16'd0;
                record_length_reg <= 16'd0;
                addr_capture_reg  <= 32'h0;
                rejected_reg      <= 1'b0;
                found_reg         <= 1'b0;
            end
            else
            begin
                phase_reg         <= phase_next;
                header_count_reg  <= header_count_next;
                skip_count_reg    <= skip_count_next;
                answers_left_reg  <= answers_left_next;
                field_count_reg   <= field_count_next;
                record_type_reg   <= record_type_next;
                record_length_reg <= record_length_next;
                addr_capture_reg  <= addr_capture_next;
                rejected_reg      <= rejected_next;
                found_reg         <= found_next;
            end
        end
    end

endmodule

// ===== hdl/dra_out_stage.sv =====
// ----------------------------------------------------------------------------
// dra_out_stage
// Result register with valid/stall handshake toward the receiver.
// ----------------------------------------------------------------------------
module dra_out_stage
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [31:0] address
);

    logic    valid_reg;
    result_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign found     = res_reg.found;
    assign address   = res_reg.address;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            res_reg <= res;
    end

endmodule

// ===== hdl/dns_response_address_parser.sv =====
// ----------------------------------------------------------------------------
// dns_response_address_parser
// Extracts the first A-record address from a DNS reply streamed byte-wise.
// ----------------------------------------------------------------------------
// Input channel: one payload byte per word (data_byte, last_byte), with the
// sender address on source_address, taken on each packet's first byte. A word
// moves when in_valid is high and in_stall is low.
// Output channel: one word (found, address) per packet, produced from the
// packet's last byte; moves when out_valid is high and out_stall is low.
// Config: cfg_valid/cfg_ready write server_address (index 0) or expected_id
// (index 1); other indexes are dropped. cfg_ready is always high.
// Throughput: one byte per cycle while in_stall is low; the input register
// feeds the parser, whose result register sits on the output. A last byte
// goes through the input register, then the result register, to out_valid.
// While the result register is held by out_stall a last byte waits in the
// input register and in_stall rises; other bytes keep flowing. Reset clears
// the parse state and both stages, and restores the configuration defaults.
// ----------------------------------------------------------------------------
module dns_response_address_parser
    import dra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic [31:0]            source_address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [31:0]            address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic [31:0] server_address_reg;
    logic [15:0] expected_id_reg;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] src_reg;

    logic        out_free;
    logic        step;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg <= SERVER_ADDR_RESET;
            expected_id_reg    <= EXPECTED_ID_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SERVER_ADDRESS: server_address_reg <= cfg_data;
                CFG_EXPECTED_ID:    expected_id_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // a last byte needs the result slot; other bytes always step
    assign step     = in_valid_reg && (!last_reg || out_free);
    assign in_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
            src_reg  <= source_address;
        end
    end

    dra_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (byte_reg),
        .last_byte      (last_reg),
        .source_address (src_reg),
        .server_address (server_address_reg),
        .expected_id    (expected_id_reg),
        .res            (res)
    );

    dra_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && last_reg),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .address   (address)
    );

endmodule
